// ===== design/swnm_pkg.sv =====
// ----------------------------------------------------------------------------
// swnm_pkg
// Shared widths, defaults, register indexes and the per-cell control type
// of the sliding window near-match unit.
// ----------------------------------------------------------------------------
package swnm_pkg;

    localparam int WINDOW_MAX_DEF = 64;
    localparam int VALUE_W        = 32;
    localparam int TOL_W          = 31;
    localparam int WSIZE_W        = 7;
    localparam int CFG_ADDR_W     = 1;
    localparam int OUT_DATA_W     = 8;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_WINDOW_SIZE = 1'b0,
        CFG_TOLERANCE   = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic load;
        logic shift;
        logic cmp;
    } t_cell_ctl;

endpackage

// ===== design/swnm_cell.sv =====
// ----------------------------------------------------------------------------
// swnm_cell
// One window cell: holds a kept value, passes it to the next cell on a
// shift and registers whether the incoming item is within tolerance of it.
// ----------------------------------------------------------------------------
module swnm_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  swnm_pkg::t_cell_ctl                 i_ctl,
    input  logic signed [swnm_pkg::VALUE_W-1:0] i_sample,
    input  logic signed [swnm_pkg::VALUE_W-1:0] i_prev,
    input  logic        [swnm_pkg::TOL_W-1:0]   i_tol,
    output logic signed [swnm_pkg::VALUE_W-1:0] o_value,
    output logic                                o_match
);

    localparam int DW = swnm_pkg::VALUE_W + 1;

    logic signed [swnm_pkg::VALUE_W-1:0] r_value;
    logic                                r_match;
    logic                                n_match;
    logic signed [DW-1:0]                diff;
    logic        [DW-1:0]                mag;

    always_comb begin
        diff    = {i_sample[swnm_pkg::VALUE_W-1], i_sample}
                - {r_value[swnm_pkg::VALUE_W-1], r_value};
        mag     = diff[DW-1] ? DW'(-diff) : DW'(diff);
        n_match = i_ctl.cmp && (mag <= {2'b00, i_tol});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_value <= i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.load) begin
            r_match <= n_match;
        end
    end

    assign o_value = r_value;
    assign o_match = r_match;

endmodule

// ===== design/sliding_window_near_match_unit.sv =====
// ----------------------------------------------------------------------------
// sliding_window_near_match_unit
// Reports for each signed sample whether a kept recent sample of the same
// sequence lies within the tolerance, plus a sticky flag for the sequence.
// ----------------------------------------------------------------------------
// Input items carry a 32-bit sample in tdata and a start flag in tuser that
// opens a new sequence and clears the window and the sticky flag.
// Each output item carries the hit bit and the sticky found bit.
// The window is a chain of cells; every cell compares its value with the
// item in parallel and registers a match bit, and on acceptance the chain
// shifts the item in at its head.
// The match bits are registered in the cells, then they are combined into the
// output register.
// One item is accepted in every cycle while the output is taken.
// When the receiver stalls, the output register and the match stage hold,
// and input tready drops once both are full.
// Synchronous reset empties the window, clears the sticky flag and sets both
// registers to zero; the window contents themselves are not cleared.
// Configuration writes leave the window contents untouched.
// ----------------------------------------------------------------------------
module sliding_window_near_match_unit #(
    parameter int WINDOW_MAX = swnm_pkg::WINDOW_MAX_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [swnm_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [swnm_pkg::TOL_W-1:0]        i_cfg_wdata,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [swnm_pkg::VALUE_W-1:0]      i_s_tdata,  // [31:0] value
    input  logic                              i_s_tuser,  // [0] start_req
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [swnm_pkg::OUT_DATA_W-1:0]   o_m_tdata   // [0] hit, [1] found
);

    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int MW = (CW > swnm_pkg::WSIZE_W) ? CW : swnm_pkg::WSIZE_W;

    logic [swnm_pkg::WSIZE_W-1:0] r_wsize;
    logic [swnm_pkg::TOL_W-1:0]   r_tol;
    logic [CW-1:0]                r_fill;
    logic [CW-1:0]                n_fill;
    logic                         r_s1_valid;
    logic                         r_s1_start;
    logic                         r_out_valid;
    logic                         r_out_hit;
    logic                         r_found;

    logic                         acc;
    logic                         adv;
    logic [MW-1:0]                ws_ext;
    logic [CW-1:0]                ksz;
    logic [CW-1:0]                base;
    logic [CW-1:0]                used;
    logic                         hit;
    logic                         n_found;

    swnm_pkg::t_cell_ctl               ctl   [WINDOW_MAX];
    logic signed [swnm_pkg::VALUE_W-1:0] chain [WINDOW_MAX+1];
    logic [WINDOW_MAX-1:0]             match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsize <= '0;
            r_tol   <= '0;
        end else if (i_cfg_we) begin
            case (swnm_pkg::t_cfg_index'(i_cfg_addr))
                swnm_pkg::CFG_WINDOW_SIZE: r_wsize <= i_cfg_wdata[swnm_pkg::WSIZE_W-1:0];
                swnm_pkg::CFG_TOLERANCE:   r_tol   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign adv        = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || adv;
    assign acc        = i_s_tvalid && o_s_tready;

    always_comb begin
        ws_ext = MW'(r_wsize);
        ksz    = (ws_ext > MW'(WINDOW_MAX)) ? CW'(WINDOW_MAX) : CW'(ws_ext);
        base   = i_s_tuser ? '0 : r_fill;
        used   = (base < ksz) ? base : ksz;
        if (ksz == '0) begin
            n_fill = '0;
        end else if (used == ksz) begin
            n_fill = ksz;
        end else begin
            n_fill = used + CW'(1);
        end
    end

    assign chain[0] = i_s_tdata;

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        assign ctl[g].load  = acc;
        assign ctl[g].shift = acc && (CW'(g) < ksz);
        assign ctl[g].cmp   = acc && (CW'(g) < used);

        swnm_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl[g]),
            .i_sample (i_s_tdata),
            .i_prev   (chain[g]),
            .i_tol    (r_tol),
            .o_value  (chain[g+1]),
            .o_match  (match[g])
        );
    end

    assign hit     = |match;
    assign n_found = (r_s1_start ? 1'b0 : r_found) | hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_s1_valid  <= 1'b0;
            r_s1_start  <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_hit   <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            if (acc) begin
                r_fill     <= n_fill;
                r_s1_start <= i_s_tuser;
            end
            if (acc) begin
                r_s1_valid <= 1'b1;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_out_hit   <= hit;
                r_found     <= n_found;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(swnm_pkg::OUT_DATA_W - 2){1'b0}}, r_found, r_out_hit};

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(WINDOW_MAX))
        else $error("fill count beyond window depth");

    a_hit_sets_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (!o_m_tdata[0] || o_m_tdata[1]))
        else $error("hit reported without found");

    a_zero_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && ksz == '0) |=> (r_fill == '0))
        else $error("zero window kept a value");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_m_tready) |-> !o_s_tready)
        else $error("item accepted while both stages stalled");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sliding window near-match unit. A directed
// table walks the extreme values, the zero, shrunk and oversized windows and
// repeated samples. Random phases with fresh register settings follow. Every
// output item is compared with the oldest expectation, from the table row or
// from an internal window model, while both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;

    localparam int WIN_DEPTH   = swnm_pkg::WINDOW_MAX_DEF;
    localparam int VALUE_W     = swnm_pkg::VALUE_W;
    localparam int TOL_W       = swnm_pkg::TOL_W;
    localparam int WSIZE_W     = swnm_pkg::WSIZE_W;
    localparam int CFG_ADDR_W  = swnm_pkg::CFG_ADDR_W;
    localparam int OUT_DATA_W  = swnm_pkg::OUT_DATA_W;
    localparam int DIR_N       = 23;
    localparam int RAND_ITEMS  = 1430;
    localparam int HOLD_CYCLES = 300;
    localparam int WDOG_LIMIT  = 2000;

    typedef struct packed {
        logic hit;
        logic found;
    } t_match;

    typedef struct packed {
        logic [WSIZE_W-1:0] wsize;
        logic [TOL_W-1:0]   tol;
        logic [VALUE_W-1:0] value;
        logic               start;
        logic               typed;
        logic               hit;
        logic               found;
    } t_vec_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [TOL_W-1:0]      i_cfg_wdata;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [VALUE_W-1:0]    i_s_tdata;
    logic                  i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    logic signed [VALUE_W-1:0] shadow_win [WIN_DEPTH];
    int unsigned               shadow_fill;
    logic                      shadow_found;
    logic [WSIZE_W-1:0]        shadow_wsize;
    logic [TOL_W-1:0]          shadow_tol;

    t_match pending_match_q [$];
    int     n_errors;
    int     idle_cycles = 0;
    bit     idle_on;
    bit     hold_off_req;

    t_vec_row dir_tab [DIR_N] = '{
        '{7'd0,   31'd0,          32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b0},
        '{7'd0,   31'd0,          32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b0},
        '{7'd4,   31'd0,          32'h0000_0005, 1'b1, 1'b1, 1'b0, 1'b0},
        '{7'd4,   31'd0,          32'h0000_0005, 1'b0, 1'b1, 1'b1, 1'b1},
        '{7'd4,   31'd0,          32'h0000_0006, 1'b0, 1'b1, 1'b0, 1'b1},
        '{7'd64,  31'h7FFF_FFFF,  32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0},
        '{7'd64,  31'h7FFF_FFFF,  32'h8000_0000, 1'b0, 1'b1, 1'b0, 1'b0},
        '{7'd64,  31'h7FFF_FFFF,  32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b1},
        '{7'd64,  31'h7FFF_FFFF,  32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b0},
        '{7'd127, 31'd1,          32'h0000_0002, 1'b0, 1'b1, 1'b0, 1'b0},
        '{7'd127, 31'd1,          32'h0000_0001, 1'b0, 1'b1, 1'b1, 1'b1},
        '{7'd2,   31'd10,         32'h0000_0064, 1'b0, 1'b0, 1'b0, 1'b0},
        '{7'd2,   31'd10,         32'h0000_005F, 1'b0, 1'b0, 1'b0, 1'b0},
        '{7'd2,   31'd10,         32'h8000_0000, 1'b1, 1'b1, 1'b0, 1'b0},
        '{7'd2,   31'd10,         32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0},
        '{7'd1,   31'd0,          32'h0000_0007, 1'b1, 1'b1, 1'b0, 1'b0},
        '{7'd1,   31'd0,          32'h0000_0007, 1'b0, 1'b1, 1'b1, 1'b1},
        '{7'd1,   31'd0,          32'h0000_0008, 1'b0, 1'b1, 1'b0, 1'b1},
        '{7'd1,   31'd0,          32'h0000_0007, 1'b0, 1'b1, 1'b0, 1'b1},
        '{7'd0,   31'h7FFF_FFFF,  32'h0000_0003, 1'b0, 1'b1, 1'b0, 1'b1},
        '{7'd0,   31'h7FFF_FFFF,  32'h0000_0003, 1'b1, 1'b1, 1'b0, 1'b0},
        '{7'd64,  31'd0,          32'hFFFF_FFFB, 1'b0, 1'b0, 1'b0, 1'b0},
        '{7'd64,  31'd0,          32'hFFFF_FFFB, 1'b0, 1'b0, 1'b0, 1'b0}
    };

    logic [VALUE_W-1:0] extreme_vals [4] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF
    };

    sliding_window_near_match_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),   // [31:0] value
        .i_s_tuser   (i_s_tuser),   // [0] start_req
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)    // [0] hit, [1] found
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_match predict_near_match(logic signed [VALUE_W-1:0] v, logic st);
        int unsigned keep;
        int unsigned used;
        longint      diff;
        t_match      res;
        keep = (int'(shadow_wsize) > WIN_DEPTH) ? WIN_DEPTH : int'(shadow_wsize);
        if (st) begin
            shadow_fill  = 0;
            shadow_found = 1'b0;
        end
        used = (shadow_fill < keep) ? shadow_fill : keep;
        res.hit = 1'b0;
        for (int i = 0; i < int'(used); i++) begin
            diff = longint'(v) - longint'(shadow_win[i]);
            if (diff < 0) begin
                diff = -diff;
            end
            if (diff <= longint'(shadow_tol)) begin
                res.hit = 1'b1;
            end
        end
        if (keep > 0) begin
            for (int i = int'(keep) - 1; i > 0; i--) begin
                shadow_win[i] = shadow_win[i-1];
            end
            shadow_win[0] = v;
            shadow_fill = (used + 1 > keep) ? keep : used + 1;
        end else begin
            shadow_fill = 0;
        end
        shadow_found = shadow_found | res.hit;
        res.found = shadow_found;
        return res;
    endfunction

    task automatic push_sample(input logic [VALUE_W-1:0] v, input logic st,
                               input logic use_typed, input t_match typed_res);
        int     gap;
        t_match pred;
        gap = idle_on ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= v;
        i_s_tuser  <= st;
        do @(posedge i_clk); while (!o_s_tready);
        pred = predict_near_match(v, st);
        pending_match_q.push_back(use_typed ? typed_res : pred);
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_match_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(input logic [WSIZE_W-1:0] ws, input logic [TOL_W-1:0] tol);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= swnm_pkg::CFG_WINDOW_SIZE;
        i_cfg_wdata <= {24'($urandom), ws};
        @(posedge i_clk);
        i_cfg_addr  <= swnm_pkg::CFG_TOLERANCE;
        i_cfg_wdata <= tol;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_wsize = ws;
        shadow_tol   = tol;
    endtask

    initial begin : sink_proc
        int stall;
        i_m_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                stall = idle_on ? $urandom_range(0, 18) : 0;
                if (stall > 0) begin
                    i_m_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    always @(posedge i_clk) begin
        t_match got;
        t_match want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.hit   = o_m_tdata[0];
            got.found = o_m_tdata[1];
            if (pending_match_q.size() == 0) begin
                $display("%0t: unexpected item, actual hit %0b found %0b",
                         $time, got.hit, got.found);
                n_errors++;
            end else begin
                want = pending_match_q.pop_front();
                if (got.hit !== want.hit) begin
                    $display("%0t: hit mismatch, expected %0b, actual %0b",
                             $time, want.hit, got.hit);
                    n_errors++;
                end
                if (got.found !== want.found) begin
                    $display("%0t: found mismatch, expected %0b, actual %0b",
                             $time, want.found, got.found);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
            $display("tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stim_proc
        int                 sent;
        int                 phase;
        int                 plen;
        logic [WSIZE_W-1:0] ws;
        logic [TOL_W-1:0]   tol;
        logic [VALUE_W-1:0] base;
        logic [VALUE_W-1:0] value;
        logic [VALUE_W-1:0] last_value;
        logic               st;
        n_errors     = 0;
        idle_on      = 1'b1;
        hold_off_req = 1'b0;
        shadow_fill  = 0;
        shadow_found = 1'b0;
        shadow_wsize = '0;
        shadow_tol   = '0;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_addr  <= swnm_pkg::CFG_WINDOW_SIZE;
        i_cfg_wdata <= '0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_N; r++) begin
            if (dir_tab[r].wsize != shadow_wsize || dir_tab[r].tol != shadow_tol) begin
                drain_results();
                configure(dir_tab[r].wsize, dir_tab[r].tol);
            end
            push_sample(dir_tab[r].value, dir_tab[r].start, dir_tab[r].typed,
                        '{hit: dir_tab[r].hit, found: dir_tab[r].found});
        end

        sent       = 0;
        phase      = 0;
        last_value = '0;
        while (sent < RAND_ITEMS) begin
            drain_results();
            case ($urandom_range(0, 5))
                0:       ws = '0;
                1:       ws = WSIZE_W'(WIN_DEPTH);
                2:       ws = WSIZE_W'($urandom_range(WIN_DEPTH + 1, 127));
                3:       ws = WSIZE_W'($urandom_range(1, 8));
                default: ws = WSIZE_W'($urandom_range(0, WIN_DEPTH));
            endcase
            case ($urandom_range(0, 4))
                0:       tol = '0;
                1:       tol = 31'h7FFF_FFFF;
                2:       tol = TOL_W'($urandom_range(0, 30));
                3:       tol = TOL_W'($urandom);
                default: tol = TOL_W'($urandom_range(0, 2000));
            endcase
            configure(ws, tol);
            idle_on = (phase < 2) || ($urandom_range(0, 3) != 0);
            if (phase == 1) begin
                hold_off_req = 1'b1;
            end
            plen = $urandom_range(20, 120);
            base = ($urandom_range(0, 3) == 0) ? extreme_vals[$urandom_range(0, 3)]
                                               : VALUE_W'($urandom);
            for (int k = 0; k < plen; k++) begin
                if (phase == 3 && k == plen / 2) begin
                    drain_results();
                end
                st = (k == 0 && $urandom_range(0, 2) != 0) || ($urandom_range(0, 24) == 0);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: value = base + VALUE_W'($urandom_range(0, 40)) - 32'd20;
                    6, 7:             value = $urandom;
                    8:                value = extreme_vals[$urandom_range(0, 3)];
                    default:          value = last_value;
                endcase
                push_sample(value, st, 1'b0, '0);
                last_value = value;
                sent++;
            end
            phase++;
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (n_errors == 0 && pending_match_q.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
